@@ rtl/ned_pkg.sv @@
// ----------------------------------------------------------------------------
// ned_pkg
// Shared constants, register codes and structs for the note event detector.
// ----------------------------------------------------------------------------
package ned_pkg;

  // Default geometry
  localparam int NOTE_COUNT_DEF = 128;
  localparam int TICK_BITS_DEF  = 16;

  // Fixed field widths
  localparam int STR_W  = 16;
  localparam int TICK_W = 16;
  localparam int NOTE_W = 7;
  localparam int VEL_W  = 7;
  localparam int PEAK_W = 16;

  // Notes per octave: distance to the octave-below note
  localparam int OCTAVE = 12;

  // Signed level width: strength minus up to about twice full scale
  localparam int LVL_W = 19;

  // Velocity scaling
  localparam int VEL_MAX   = 127;
  localparam int VEL_SHIFT = 20;

  // Output queue depth
  localparam int OUT_DEPTH = 4;

  // Configuration port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_ON_THR   = 3'd0,
    REG_OFF_THR  = 3'd1,
    REG_OCT_GAIN = 3'd2,
    REG_MIN_LEN  = 3'd3,
    REG_VEL_GAIN = 3'd4
  } reg_idx_t;

  localparam logic [15:0] ON_THR_RST   = 16'd8192;
  localparam logic [15:0] OFF_THR_RST  = 16'd4096;
  localparam logic [15:0] OCT_GAIN_RST = 16'd0;
  localparam logic [15:0] MIN_LEN_RST  = 16'd2;
  localparam logic [15:0] VEL_GAIN_RST = 16'd4096;

  typedef struct packed {
    logic signed [15:0] on_thr;
    logic signed [15:0] off_thr;
    logic [15:0]        oct_gain;
    logic [15:0]        min_len;
    logic [15:0]        vel_gain;
  } cfg_t;

  // Finished note on its way to velocity scaling
  typedef struct packed {
    logic              valid;
    logic [TICK_W-1:0] start_tick;
    logic [TICK_W-1:0] stop_tick;
    logic [NOTE_W-1:0] note_number;
    logic [PEAK_W-1:0] peak;
  } cand_t;

  // Occupancy of the detector stages
  typedef struct packed {
    logic s1_busy;
    logic cand_busy;
  } flight_t;

  typedef struct packed {
    logic [TICK_W-1:0] start_tick;
    logic [TICK_W-1:0] stop_tick;
    logic [NOTE_W-1:0] note_number;
    logic [VEL_W-1:0]  velocity;
  } event_t;

endpackage

@@ rtl/ned_in_if.sv @@
// ----------------------------------------------------------------------------
// ned_in_if
// Strength item channel: valid/ready with strength and last-tick mark.
// ----------------------------------------------------------------------------
interface ned_in_if;
  import ned_pkg::*;

  logic             valid;
  logic             ready;
  logic [STR_W-1:0] strength;
  logic             last_tick;

  modport source (output valid, output strength, output last_tick, input ready);
  modport sink   (input valid, input strength, input last_tick, output ready);
endinterface

@@ rtl/ned_out_if.sv @@
// ----------------------------------------------------------------------------
// ned_out_if
// Note event channel: valid/ready with start, stop, note and velocity.
// ----------------------------------------------------------------------------
interface ned_out_if;
  import ned_pkg::*;

  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] start_tick;
  logic [TICK_W-1:0] stop_tick;
  logic [NOTE_W-1:0] note_number;
  logic [VEL_W-1:0]  velocity;

  modport source (output valid, output start_tick, output stop_tick,
                  output note_number, output velocity, input ready);
  modport sink   (input valid, input start_tick, input stop_tick,
                  input note_number, input velocity, output ready);
endinterface

@@ rtl/ned_config.sv @@
// ----------------------------------------------------------------------------
// ned_config
// APB register file holding thresholds, gains and minimum note length.
// ----------------------------------------------------------------------------
module ned_config (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ned_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [ned_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [ned_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready,
  output ned_pkg::cfg_t                    cfg
);
  import ned_pkg::*;

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_thr   <= ON_THR_RST;
      cfg.off_thr  <= OFF_THR_RST;
      cfg.oct_gain <= OCT_GAIN_RST;
      cfg.min_len  <= MIN_LEN_RST;
      cfg.vel_gain <= VEL_GAIN_RST;
    end else if (wr_en) begin
      case (idx)
        REG_ON_THR:   cfg.on_thr   <= pwdata[15:0];
        REG_OFF_THR:  cfg.off_thr  <= pwdata[15:0];
        REG_OCT_GAIN: cfg.oct_gain <= pwdata[15:0];
        REG_MIN_LEN:  cfg.min_len  <= pwdata[15:0];
        REG_VEL_GAIN: cfg.vel_gain <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_ON_THR:   prdata = APB_DATA_W'(cfg.on_thr[15:0]);
      REG_OFF_THR:  prdata = APB_DATA_W'(cfg.off_thr[15:0]);
      REG_OCT_GAIN: prdata = APB_DATA_W'(cfg.oct_gain);
      REG_MIN_LEN:  prdata = APB_DATA_W'(cfg.min_len);
      REG_VEL_GAIN: prdata = APB_DATA_W'(cfg.vel_gain);
      default:      prdata = '0;
    endcase
  end

endmodule

@@ rtl/ned_detect.sv @@
// ----------------------------------------------------------------------------
// ned_detect
// Per-note hysteresis detector. Onset and peak live in a note-indexed RAM,
// read at accept and written back in the next cycle; playing flags are flops.
// ----------------------------------------------------------------------------
module ned_detect #(
  parameter int NOTE_COUNT = ned_pkg::NOTE_COUNT_DEF,
  parameter int TICK_BITS  = ned_pkg::TICK_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ned_pkg::cfg_t             cfg,
  input  logic                      accept,
  input  logic [ned_pkg::STR_W-1:0] strength,
  input  logic                      last_tick,
  output ned_pkg::cand_t            cand,
  output ned_pkg::flight_t          flight
);
  import ned_pkg::*;

  localparam int NB    = $clog2(NOTE_COUNT);
  localparam int LW    = (TICK_BITS > TICK_W) ? TICK_BITS : TICK_W;
  localparam int MEM_W = TICK_BITS + PEAK_W;
  localparam logic [NB-1:0]        LAST_NOTE = NB'(NOTE_COUNT - 1);
  localparam logic [NB-1:0]        OCT_NOTE  = NB'(OCTAVE);
  localparam logic [TICK_BITS-1:0] TICK_MAX  = '1;

  // Position counters
  logic [NB-1:0]        note_ctr;
  logic [TICK_BITS-1:0] tick_ctr;

  // Octave-below strengths: tap OCTAVE-1 holds the item twelve notes back
  logic [STR_W-1:0] oct_line [OCTAVE];

  // Stage 1 registers
  logic                 s1_valid;
  logic [STR_W-1:0]     s1_strength;
  logic                 s1_last;
  logic [NB-1:0]        s1_note;
  logic [TICK_BITS-1:0] s1_tick;
  logic [31:0]          s1_prod;
  logic                 s1_oct;

  // Per-note store
  logic [MEM_W-1:0]      mem [NOTE_COUNT];
  logic [MEM_W-1:0]      rd_q;
  logic [MEM_W-1:0]      wr_d;
  logic [NOTE_COUNT-1:0] playing;

  // Stage 1 datapath
  logic [32:0]           rnd_sum;
  logic [17:0]           oct_term;
  logic signed [LVL_W-1:0] level;
  logic signed [LVL_W-1:0] on_lvl;
  logic signed [LVL_W-1:0] off_lvl;
  logic                  play;
  logic [TICK_BITS-1:0]  onset;
  logic [PEAK_W-1:0]     peak;
  logic [TICK_BITS-1:0]  ev_onset;
  logic [PEAK_W-1:0]     ev_peak;
  logic [TICK_BITS-1:0]  end_t;
  logic [TICK_BITS-1:0]  width;
  logic [TICK_BITS-1:0]  span;
  logic                  emit;
  logic [LW-1:0]         begin_ext;
  logic [LW-1:0]         end_ext;

  // Advance note and tick counters; end of track rewinds both
  always_ff @(posedge clk) begin
    if (rst) begin
      note_ctr <= '0;
      tick_ctr <= '0;
    end else if (accept) begin
      if (note_ctr == LAST_NOTE) begin
        note_ctr <= '0;
        if (last_tick) begin
          tick_ctr <= '0;
        end else if (tick_ctr != TICK_MAX) begin
          tick_ctr <= tick_ctr + 1'b1;
        end
      end else begin
        note_ctr <= note_ctr + 1'b1;
      end
    end
  end

  // Shift strengths along the octave line
  always_ff @(posedge clk) begin
    if (accept) begin
      oct_line[0] <= strength;
      for (int i = 1; i < OCTAVE; i++) begin
        oct_line[i] <= oct_line[i-1];
      end
    end
  end

  // Capture the item and the octave product
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_strength <= strength;
      s1_last     <= last_tick;
      s1_note     <= note_ctr;
      s1_tick     <= tick_ctr;
      s1_prod     <= 32'(oct_line[OCTAVE-1]) * 32'(cfg.oct_gain);
      s1_oct      <= (note_ctr >= OCT_NOTE);
    end
  end

  // Read the note entry at accept, write it back from stage 1
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q <= mem[note_ctr];
    end
    if (s1_valid) begin
      mem[s1_note] <= wr_d;
    end
  end

  // Level after octave removal
  always_comb begin
    rnd_sum  = {1'b0, s1_prod} + 33'd16384;
    oct_term = s1_oct ? rnd_sum[32:15] : '0;
    level    = $signed({3'b000, s1_strength}) - $signed({1'b0, oct_term});
    on_lvl   = $signed({{(LVL_W-16){cfg.on_thr[15]}}, cfg.on_thr});
    off_lvl  = $signed({{(LVL_W-16){cfg.off_thr[15]}}, cfg.off_thr});
  end

  // Hysteresis: turn on, track peak, turn off, flush on last tick
  always_comb begin
    play  = playing[s1_note];
    onset = rd_q[MEM_W-1:PEAK_W];
    peak  = rd_q[PEAK_W-1:0];
    emit  = 1'b0;
    end_t = s1_tick;
    width = (s1_tick == TICK_MAX) ? s1_tick : s1_tick + 1'b1;

    if (!play && level >= on_lvl) begin
      play  = 1'b1;
      onset = s1_tick;
      peak  = '0;
    end
    if (play && level > $signed({3'b000, peak})) begin
      peak = level[PEAK_W-1:0];
    end
    ev_onset = onset;
    ev_peak  = peak;

    if (play && level <= off_lvl) begin
      play = 1'b0;
      span = s1_tick - onset;
      if (LW'(span) >= LW'(cfg.min_len)) begin
        emit = 1'b1;
      end
      peak = '0;
    end

    span = width - onset;
    if (s1_last) begin
      if (play && LW'(span) >= LW'(cfg.min_len)) begin
        emit  = 1'b1;
        end_t = width;
      end
      play  = 1'b0;
      peak  = '0;
      onset = '0;
    end

    wr_d      = {onset, peak};
    begin_ext = LW'(ev_onset);
    end_ext   = LW'(end_t);
  end

  // Update playing flags; the track's final note clears every flag
  always_ff @(posedge clk) begin
    if (rst) begin
      playing <= '0;
    end else if (s1_valid) begin
      if (s1_last && s1_note == LAST_NOTE) begin
        playing <= '0;
      end else begin
        playing[s1_note] <= play;
      end
    end
  end

  // Register the finished note
  always_ff @(posedge clk) begin
    if (rst) begin
      cand.valid <= 1'b0;
    end else begin
      cand.valid <= s1_valid && emit;
    end
    cand.start_tick  <= begin_ext[TICK_W-1:0];
    cand.stop_tick   <= end_ext[TICK_W-1:0];
    cand.note_number <= NOTE_W'(s1_note);
    cand.peak        <= ev_peak;
  end

  assign flight.s1_busy   = s1_valid;
  assign flight.cand_busy = cand.valid;

endmodule

@@ rtl/ned_event.sv @@
// ----------------------------------------------------------------------------
// ned_event
// Velocity scaling and output queue. Input ready reserves a queue slot for
// every item still in the detector.
// ----------------------------------------------------------------------------
module ned_event (
  input  logic             clk,
  input  logic             rst,
  input  ned_pkg::cfg_t    cfg,
  input  ned_pkg::cand_t   cand,
  input  ned_pkg::flight_t flight,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output ned_pkg::event_t  out_item
);
  import ned_pkg::*;

  localparam int PB = $clog2(OUT_DEPTH);

  logic [31:0]              vel_prod;
  logic [32:0]              vel_sum;
  logic [32-VEL_SHIFT:0]    vel_raw;
  logic [VEL_W-1:0]         vel;
  event_t                   q [OUT_DEPTH];
  logic [PB-1:0]            wr_ptr;
  logic [PB-1:0]            rd_ptr;
  logic [PB:0]              count;
  logic [PB+1:0]            pending;
  logic                     push;
  logic                     pop;

  // Velocity: round(peak * gain / 2^20), capped
  always_comb begin
    vel_prod = 32'(cand.peak) * 32'(cfg.vel_gain);
    vel_sum  = {1'b0, vel_prod} + (33'd1 << (VEL_SHIFT - 1));
    vel_raw  = vel_sum[32:VEL_SHIFT];
    vel      = (vel_raw > ($bits(vel_raw))'(VEL_MAX)) ? VEL_W'(VEL_MAX)
                                                       : vel_raw[VEL_W-1:0];
  end

  assign push      = cand.valid;
  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign out_item  = q[rd_ptr];

  // Accept only while every item in flight has a slot
  always_comb begin
    pending  = (PB+2)'(count) + (PB+2)'(flight.s1_busy) + (PB+2)'(flight.cand_busy);
    in_ready = (pending < (PB+2)'(OUT_DEPTH));
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{start_tick:  cand.start_tick,
                     stop_tick:   cand.stop_tick,
                     note_number: cand.note_number,
                     velocity:    vel};
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/note_event_detector.sv @@
// ----------------------------------------------------------------------------
// note_event_detector
// Per-note onset/offset detection over a stream of note strengths.
// ----------------------------------------------------------------------------
// Path: the item that ends a note is registered in stage 1, its event in the
// candidate register and then in the event queue, from which it is presented.
// Throughput: one strength item per cycle; input stalls only when the 4-entry
// event queue plus the items still in the detector would overflow it.
// Reset: clears counters, playing flags and the output queue at once; the
// RAM needs no clearing since an entry is only used for a playing note.
module note_event_detector #(
  parameter int NOTE_COUNT = ned_pkg::NOTE_COUNT_DEF,
  parameter int TICK_BITS  = ned_pkg::TICK_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ned_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [ned_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ned_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  ned_in_if.sink                         notes,
  ned_out_if.source                      events
);
  import ned_pkg::*;

  cfg_t    cfg;
  cand_t   cand;
  flight_t flight;
  event_t  out_item;
  logic    accept;
  logic    in_ready;

  assign notes.ready = in_ready;
  assign accept      = notes.valid && in_ready;

  ned_config u_config (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ned_detect #(
    .NOTE_COUNT (NOTE_COUNT),
    .TICK_BITS  (TICK_BITS)
  ) u_detect (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .strength  (notes.strength),
    .last_tick (notes.last_tick),
    .cand      (cand),
    .flight    (flight)
  );

  ned_event u_event (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cand      (cand),
    .flight    (flight),
    .in_ready  (in_ready),
    .out_valid (events.valid),
    .out_ready (events.ready),
    .out_item  (out_item)
  );

  assign events.start_tick  = out_item.start_tick;
  assign events.stop_tick   = out_item.stop_tick;
  assign events.note_number = out_item.note_number;
  assign events.velocity    = out_item.velocity;

endmodule

@@ rtl/ned_checker.sv @@
// ----------------------------------------------------------------------------
// ned_checker
// Port-level checks on reset, result latency and output stall behavior.
// ----------------------------------------------------------------------------
module ned_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] start_tick,
  input logic [15:0] stop_tick,
  input logic [6:0]  velocity
);

  logic in_acc;

  assign in_acc = in_valid && in_ready;

  // Reset empties the output side
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // A result from an empty output needs a matching item accepted earlier at the input
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_acc, 3))
    else $error("result without matching item");

  // Hold a stalled result
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(start_tick) && $stable(stop_tick) &&
      $stable(velocity))
    else $error("stalled result changed");

endmodule

bind note_event_detector ned_checker u_ned_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (notes.valid),
  .in_ready   (notes.ready),
  .out_valid  (events.valid),
  .out_ready  (events.ready),
  .start_tick (events.start_tick),
  .stop_tick  (events.stop_tick),
  .velocity   (events.velocity)
);

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives strength items through the note event detector, with random gaps on
// the input and random stalls on the event output, across several register
// settings. A scoreboard predicts each note event and checks the emitted
// events field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
  import ned_pkg::*;

  localparam int NOTES = NOTE_COUNT_DEF;
  localparam logic [TICK_W-1:0] TICK_TOP = '1;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS = 100;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts note events from accepted strength items
  // --------------------------------------------------------------------------
  class ned_scoreboard;
    logic signed [15:0] on_thr;
    logic signed [15:0] off_thr;
    logic [15:0]        oct_gain;
    logic [15:0]        min_len;
    logic [15:0]        vel_gain;

    bit                playing [NOTES];
    logic [TICK_W-1:0] onset [NOTES];
    logic [PEAK_W-1:0] peak [NOTES];
    logic [STR_W-1:0]  below [OCTAVE];
    logic [NOTE_W-1:0] note_idx;
    logic [TICK_W-1:0] tick_idx;

    event_t due_events [$];
    int     predicted;
    int     errors;

    function new();
      on_thr    = ON_THR_RST;
      off_thr   = OFF_THR_RST;
      oct_gain  = OCT_GAIN_RST;
      min_len   = MIN_LEN_RST;
      vel_gain  = VEL_GAIN_RST;
      predicted = 0;
      errors    = 0;
      reset_tracks();
    endfunction

    // Drop every note, the octave history and both counters
    function void reset_tracks();
      foreach (playing[i]) begin
        playing[i] = 1'b0;
        onset[i]   = '0;
        peak[i]    = '0;
      end
      foreach (below[i]) below[i] = '0;
      note_idx = '0;
      tick_idx = '0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [15:0] v);
      case (idx)
        REG_ON_THR:   on_thr   = v;
        REG_OFF_THR:  off_thr  = v;
        REG_OCT_GAIN: oct_gain = v;
        REG_MIN_LEN:  min_len  = v;
        REG_VEL_GAIN: vel_gain = v;
        default: ;
      endcase
    endfunction

    // Scale the peak to a velocity and queue the finished note
    function void add_event(logic [TICK_W-1:0] b, logic [TICK_W-1:0] e,
                            logic [NOTE_W-1:0] n, logic [PEAK_W-1:0] pk);
      event_t          ev;
      longint unsigned v;
      v = (64'(pk) * 64'(vel_gain) + (64'd1 << (VEL_SHIFT - 1))) >> VEL_SHIFT;
      ev.start_tick  = b;
      ev.stop_tick   = e;
      ev.note_number = n;
      ev.velocity    = (v > VEL_MAX) ? VEL_W'(VEL_MAX) : v[VEL_W-1:0];
      due_events.insert(due_events.size(), ev);
      predicted++;
    endfunction

    function void take_strength(logic [STR_W-1:0] s, logic lt);
      int n;
      int t;
      int slot;
      int level;
      int stop;
      n     = note_idx;
      t     = tick_idx;
      slot  = n % OCTAVE;
      level = s;
      // remove the scaled octave-below strength of this tick
      if (n >= OCTAVE)
        level -= int'((64'(below[slot]) * 64'(oct_gain) + 64'd16384) >> 15);
      below[slot] = s;
      // start a note
      if (!playing[n] && level >= int'(on_thr)) begin
        playing[n] = 1'b1;
        onset[n]   = TICK_W'(t);
        peak[n]    = '0;
      end
      // hold the peak
      if (playing[n] && level > int'(peak[n])) peak[n] = level[PEAK_W-1:0];
      // end a note, emit it if long enough
      if (playing[n] && level <= int'(off_thr)) begin
        playing[n] = 1'b0;
        if (t - int'(onset[n]) >= int'(min_len))
          add_event(onset[n], TICK_W'(t), n[NOTE_W-1:0], peak[n]);
        peak[n] = '0;
      end
      // flush this note at the end of the track
      if (lt) begin
        if (playing[n]) begin
          stop = (t < int'(TICK_TOP)) ? t + 1 : t;
          if (stop - int'(onset[n]) >= int'(min_len))
            add_event(onset[n], TICK_W'(stop), n[NOTE_W-1:0], peak[n]);
        end
        playing[n] = 1'b0;
        peak[n]    = '0;
        onset[n]   = '0;
      end
      // advance note and tick, clear all after a final tick
      if (n == NOTES - 1) begin
        if (lt) begin
          reset_tracks();
        end else begin
          note_idx = '0;
          if (tick_idx != TICK_TOP) tick_idx++;
        end
      end else begin
        note_idx++;
      end
    endfunction

    function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void match_event(event_t got);
      event_t want;
      if (due_events.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("note event with none expected: note %0d start %0d stop %0d vel %0d",
                 got.note_number, got.start_tick, got.stop_tick, got.velocity);
        return;
      end
      want = due_events.pop_front();
      cmp_field("start_tick", want.start_tick, got.start_tick);
      cmp_field("stop_tick", want.stop_tick, got.stop_tick);
      cmp_field("note_number", 16'(want.note_number), 16'(got.note_number));
      cmp_field("velocity", 16'(want.velocity), 16'(got.velocity));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block and channels
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  ned_in_if  note_ch();
  ned_out_if event_ch();

  note_event_detector uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .notes   (note_ch),
    .events  (event_ch)
  );

  ned_scoreboard sb;
  event_t        seen;
  bit            calm = 1'b0;

  // Position of the stimulus in the track
  bit gen_active [NOTES];
  int gen_note   = 0;
  int gen_tick   = 0;
  int track_len  = 4;
  int final_mode = 0;

  // --------------------------------------------------------------------------
  // Clock and time limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  // Stall the event output at random, except in calm stretches
  initial begin
    event_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      event_ch.ready <= calm || ($urandom_range(99, 0) >= 28);
    end
  end

  // Sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (note_ch.valid && note_ch.ready)
        sb.take_strength(note_ch.strength, note_ch.last_tick);
      if (event_ch.valid && event_ch.ready) begin
        seen.start_tick  = event_ch.start_tick;
        seen.stop_tick   = event_ch.stop_tick;
        seen.note_number = event_ch.note_number;
        seen.velocity    = event_ch.velocity;
        sb.match_event(seen);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic write_reg(input reg_idx_t idx, input logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, v};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic load_config(input logic [15:0] on_v, input logic [15:0] off_v,
                             input logic [15:0] oct_v, input logic [15:0] min_v,
                             input logic [15:0] vel_v);
    write_reg(REG_ON_THR, on_v);
    write_reg(REG_OFF_THR, off_v);
    write_reg(REG_OCT_GAIN, oct_v);
    write_reg(REG_MIN_LEN, min_v);
    write_reg(REG_VEL_GAIN, vel_v);
  endtask

  task automatic send_item(input logic [STR_W-1:0] s, input logic lt);
    // idle at random before the item
    while (!calm && $urandom_range(99, 0) < 28) begin
      note_ch.valid <= 1'b0;
      @(negedge clk);
    end
    note_ch.valid     <= 1'b1;
    note_ch.strength  <= s;
    note_ch.last_tick <= lt;
    @(posedge clk);
    while (!note_ch.ready) @(posedge clk);
    @(negedge clk);
    // follow the track position; a final note with the mark starts a new track
    if (gen_note == NOTES - 1) begin
      gen_note = 0;
      if (lt) begin
        gen_tick   = 0;
        track_len  = $urandom_range(8, 2);
        final_mode = $urandom_range(99, 0);
        final_mode = (final_mode < 70) ? 0 : (final_mode < 85) ? 1 : 2;
      end else begin
        gen_tick++;
      end
    end else begin
      gen_note++;
    end
  endtask

  // Mostly notes that rise above on and fall below off, some noise
  task automatic run_random(input int min_items, input int min_events);
    int               sent;
    int               start;
    int               lo;
    int               hi;
    logic [STR_W-1:0] s;
    logic             lt;
    sent  = 0;
    start = sb.predicted;
    while ((sent < min_items || sb.predicted - start < min_events) && sent < 4000) begin
      lo = int'(sb.on_thr);
      hi = int'(sb.off_thr);
      if ($urandom_range(9, 0) == 0) begin
        s = STR_W'($urandom());
      end else begin
        if ($urandom_range(3, 0) == 0) gen_active[gen_note] = !gen_active[gen_note];
        if (gen_active[gen_note])
          s = STR_W'($urandom_range(65535, (lo < 0) ? 0 : lo));
        else
          s = (hi < 0) ? '0 : STR_W'($urandom_range(hi, 0));
      end
      if (gen_tick >= track_len - 1) begin
        case (final_mode)
          0:       lt = 1'b1;
          1:       lt = (gen_note == NOTES - 1);
          default: lt = (gen_note == NOTES - 1) || ($urandom_range(1, 0) == 1);
        endcase
      end else begin
        lt = ($urandom_range(49, 0) == 0);
      end
      send_item(s, lt);
      sent++;
    end
  endtask

  // Drop valid, wait out all expected events and the pipeline
  task automatic settle();
    note_ch.valid <= 1'b0;
    while (sb.due_events.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [16:0] directed [25];
    logic [15:0] on_v;
    logic [15:0] off_v;
    logic [15:0] oct_v;

    // {last_tick, strength}: extremes, on and off in one item, a lone flush,
    // octave subtraction down to zero and below
    directed = '{17'h0_0000, 17'h0_FFFF, 17'h0_4000, 17'h0_3FFF, 17'h0_8000,
                 17'h1_FFFF, 17'h1_0000, 17'h0_5555, 17'h0_AAAA, 17'h0_4001,
                 17'h0_7FFF, 17'h0_0001, 17'h0_FFFF, 17'h0_FFFF, 17'h0_8000,
                 17'h0_0000, 17'h0_C000, 17'h1_0000, 17'h0_1234, 17'h0_EDCB,
                 17'h1_0F0F, 17'h0_F0F0, 17'h0_8001, 17'h0_7FFE, 17'h0_FFFE};

    sb                = new();
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    note_ch.valid     = 1'b0;
    note_ch.strength  = '0;
    note_ch.last_tick = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // equal thresholds, unity octave gain, no length floor
    load_config(16'd16384, 16'd16384, 16'd32768, 16'd0, 16'd8192);
    foreach (directed[i]) send_item(directed[i][15:0], directed[i][16]);
    run_random(60, 0);
    settle();

    // lowest on, highest off: most items are zero-length notes
    load_config(16'h8000, 16'h7FFF, 16'hFFFF, 16'd0, 16'd0);
    calm = 1'b1;
    run_random(100, 0);
    calm = 1'b0;
    run_random(100, 0);
    settle();

    // highest on, lowest off, longest floor: notes never emit
    load_config(16'h7FFF, 16'h8000, 16'd0, 16'hFFFF, 16'hFFFF);
    run_random(60, 0);
    settle();

    // values after reset
    load_config(ON_THR_RST, OFF_THR_RST, OCT_GAIN_RST, MIN_LEN_RST, VEL_GAIN_RST);
    run_random(60, 0);
    settle();

    // random settings, mostly with hysteresis
    repeat (3) begin
      on_v  = 16'($urandom_range(26000, 3000));
      off_v = ($urandom_range(3, 0) == 0) ? 16'($urandom_range(32767, 0))
                                          : 16'($urandom_range(on_v, 0));
      case ($urandom_range(2, 0))
        0:       oct_v = 16'd0;
        1:       oct_v = 16'($urandom_range(20000, 0));
        default: oct_v = 16'($urandom());
      endcase
      load_config(on_v, off_v, oct_v, 16'($urandom_range(4, 0)), 16'($urandom()));
      run_random(60, 0);
      settle();
    end

    if (sb.errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
